/* rtl/bitmap_pixel_unpacker_assert.svh */
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker assertion macros
// Concurrent assertion wrappers shared by the RTL; they vanish when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PIXEL_UNPACKER_ASSERT_SVH
`define BITMAP_PIXEL_UNPACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define BPU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BPU_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/bpu_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker package
// Field widths, format codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bpu_pkg;

  // Payload field widths.
  localparam int OP_W     = 1;
  localparam int BYTE_W   = 8;
  localparam int PIDX_W   = 8;
  localparam int COLOR_W  = 24;
  localparam int COORD_W  = 12;

  // Configuration port.
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;
  localparam int FMT_W    = 3;
  localparam int DIM_W    = 13;

  // Default sizes.
  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_PIXEL   = 1'b0;
  localparam logic [OP_W-1:0] OP_PALETTE = 1'b1;

  // Pixel format codes.
  localparam logic [FMT_W-1:0] FMT_1BPP  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_16BPP = 3'd3;
  localparam logic [FMT_W-1:0] FMT_24BPP = 3'd4;
  localparam logic [FMT_W-1:0] FMT_32BPP = 3'd5;

  // Register indexes (byte address is 4 times the index).
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_FLIP   = 2'd3;

  // Register reset values.
  localparam logic [FMT_W-1:0] FORMAT_RST = FMT_24BPP;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic             FLIP_RST   = 1'b1;

endpackage

`default_nettype wire

/* rtl/bpu_in_if.sv */
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker input channel
// Valid/ready channel carrying pixel stream bytes and palette writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpu_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpu_pkg::OP_W-1:0]      operation;
  logic [bpu_pkg::BYTE_W-1:0]    data_byte;
  logic [bpu_pkg::PIDX_W-1:0]    palette_index;
  logic [bpu_pkg::COLOR_W-1:0]   palette_color;

  modport source (
    output valid, operation, data_byte, palette_index, palette_color,
    input  ready
  );

  modport sink (
    input  valid, operation, data_byte, palette_index, palette_color,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bpu_out_if.sv */
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker output channel
// Valid/ready channel carrying one decoded pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpu_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpu_pkg::COLOR_W-1:0]   pixel_color;
  logic [bpu_pkg::COORD_W-1:0]   column;
  logic [bpu_pkg::COORD_W-1:0]   row_number;
  logic                          row_last;
  logic                          frame_last;
  logic                          run_last;

  modport source (
    output valid, pixel_color, column, row_number, row_last, frame_last, run_last,
    input  ready
  );

  modport sink (
    input  valid, pixel_color, column, row_number, row_last, frame_last, run_last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bitmap_pixel_unpacker.sv */
// ----------------------------------------------------------------------------
// Bitmap pixel unpacker
// Turns raw bitmap row bytes into 24-bit pixels with row and column tags.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Moves
//  pix_in    in         valid/ready      stream byte or palette write
//  pix_out   out        valid/ready      one pixel with position and flags
//  apb       in         psel/penable     register write and read
//
//  A transaction sits in a byte register and its pixels leave through an
//  output register, which presents each pixel on pix_out.
//  Direct formats, 8 bpp, pad bytes and palette writes leave the byte
//  register once handled; 4 bpp holds it for up to 2 pixels and 1 bpp up
//  to 8, one pixel per cycle unless the output stalls, through the single
//  palette read port. Reset clears counters and handshake state; the palette
//  holds whatever it held until written. A stalled output holds the byte
//  register, which keeps pix_in.ready low until its last pixel moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_pixel_unpacker #(
  parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = bpu_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpu_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bpu_pkg::PDATA_W-1:0]   pwdata,
  output      logic [bpu_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready,
  bpu_in_if.sink                             pix_in,
  bpu_out_if.source                          pix_out
);

  // Counter widths follow from the size limits.
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int BW = CW + 2;
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Configuration registers.
  logic [bpu_pkg::FMT_W-1:0] pixel_format;
  logic [bpu_pkg::DIM_W-1:0] row_width;
  logic [bpu_pkg::DIM_W-1:0] image_height;
  logic                      bottom_up;
  logic                      cfg_we;

  // Frame state.
  logic [23:0]   byte_gather;
  logic [1:0]    byte_phase;
  logic [BW-1:0] row_byte_count;
  logic [CW-1:0] column_count;
  logic [HW-1:0] row_count;

  // Byte register.
  logic                           s1_valid;
  logic [bpu_pkg::OP_W-1:0]       s1_op;
  logic [bpu_pkg::BYTE_W-1:0]     s1_byte;
  logic [bpu_pkg::PIDX_W-1:0]     s1_pidx;
  logic [bpu_pkg::COLOR_W-1:0]    s1_pcolor;
  logic [2:0]                     s1_k;

  // Output register.
  logic                           s2_valid;
  logic                           s2_use_pal;
  logic                           s2_pal_ok;
  logic [bpu_pkg::COLOR_W-1:0]    s2_direct;
  logic [bpu_pkg::COLOR_W-1:0]    s2_pal_rd;
  logic [bpu_pkg::COORD_W-1:0]    s2_column;
  logic [bpu_pkg::COORD_W-1:0]    s2_row;
  logic                           s2_row_last;
  logic                           s2_frame_last;
  logic                           s2_run_last;

  // Palette memory.
  logic [bpu_pkg::COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

  // Decode logic.
  logic [bpu_pkg::FMT_W-1:0] fmt_eff;
  logic [CW-1:0]             eff_w;
  logic [HW-1:0]             eff_h;
  logic [BW-1:0]             w_ext;
  logic [BW-1:0]             nbytes;
  logic [BW-1:0]             nb_plus3;
  logic [BW-1:0]             padded;
  logic [BW-1:0]             rbc_inc;
  logic                      is_pal_fmt;
  logic                      in_data;
  logic                      col_ok;
  logic                      row_last;
  logic                      frame_last;
  logic [HW-1:0]             rowno;
  logic [2:0]                sh;
  logic [7:0]                bsh;
  logic [bpu_pkg::PIDX_W-1:0] pal_idx;
  logic                      pal_idx_ok;
  logic                      last_k;
  logic [23:0]               gather_new;
  logic [1:0]                phase_new;
  logic [1:0]                phase_need;
  logic                      fire;
  logic [bpu_pkg::COLOR_W-1:0] direct_color;
  logic                      emit;
  logic                      run_last;
  logic                      is_data;
  logic                      s2_free;
  logic                      step_ok;
  logic                      byte_done;
  logic                      s1_done;
  logic                      in_take;
  logic                      pwr_ok;

  // APB access: writes land at the access phase, reads are combinational.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      bpu_pkg::REG_FORMAT: prdata = bpu_pkg::PDATA_W'(pixel_format);
      bpu_pkg::REG_WIDTH:  prdata = bpu_pkg::PDATA_W'(row_width);
      bpu_pkg::REG_HEIGHT: prdata = bpu_pkg::PDATA_W'(image_height);
      bpu_pkg::REG_FLIP:   prdata = bpu_pkg::PDATA_W'(bottom_up);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= bpu_pkg::FORMAT_RST;
      row_width    <= bpu_pkg::WIDTH_RST;
      image_height <= bpu_pkg::HEIGHT_RST;
      bottom_up    <= bpu_pkg::FLIP_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        bpu_pkg::REG_FORMAT: pixel_format <= pwdata[bpu_pkg::FMT_W-1:0];
        bpu_pkg::REG_WIDTH:  row_width    <= pwdata[bpu_pkg::DIM_W-1:0];
        bpu_pkg::REG_HEIGHT: image_height <= pwdata[bpu_pkg::DIM_W-1:0];
        bpu_pkg::REG_FLIP:   bottom_up    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Effective format and clamped image size.
  always_comb begin
    fmt_eff = (pixel_format > bpu_pkg::FMT_32BPP) ? bpu_pkg::FMT_32BPP : pixel_format;
    if (row_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(row_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(row_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  // Data bytes per stored row and the padded row length.
  always_comb begin
    w_ext = BW'(eff_w);
    case (fmt_eff)
      bpu_pkg::FMT_1BPP:  nbytes = (w_ext + BW'(7)) >> 3;
      bpu_pkg::FMT_4BPP:  nbytes = (w_ext + BW'(1)) >> 1;
      bpu_pkg::FMT_8BPP:  nbytes = w_ext;
      bpu_pkg::FMT_16BPP: nbytes = w_ext << 1;
      bpu_pkg::FMT_24BPP: nbytes = w_ext + (w_ext << 1);
      default:            nbytes = w_ext << 2;
    endcase
    nb_plus3 = nbytes + BW'(3);
    padded   = {nb_plus3[BW-1:2], 2'b00};
    rbc_inc  = row_byte_count + BW'(1);
  end

  // Position of the pixel being formed.
  always_comb begin
    is_pal_fmt = fmt_eff inside {bpu_pkg::FMT_1BPP, bpu_pkg::FMT_4BPP, bpu_pkg::FMT_8BPP};
    in_data    = row_byte_count < nbytes;
    col_ok     = column_count < eff_w;
    row_last   = ({1'b0, column_count} + (CW+1)'(1)) >= {1'b0, eff_w};
    frame_last = row_last && (({1'b0, row_count} + (HW+1)'(1)) >= {1'b0, eff_h});
    rowno      = bottom_up ? (eff_h - HW'(1) - row_count) : row_count;
  end

  // Palette index extraction, most significant pixel first.
  always_comb begin
    case (fmt_eff)
      bpu_pkg::FMT_1BPP: sh = s1_k;
      bpu_pkg::FMT_4BPP: sh = {s1_k[0], 2'b00};
      default:           sh = 3'd0;
    endcase
    bsh = s1_byte << sh;
    case (fmt_eff)
      bpu_pkg::FMT_1BPP: begin
        pal_idx = bpu_pkg::PIDX_W'(bsh[7]);
        last_k  = (s1_k == 3'd7);
      end
      bpu_pkg::FMT_4BPP: begin
        pal_idx = bpu_pkg::PIDX_W'(bsh[7:4]);
        last_k  = (s1_k == 3'd1);
      end
      default: begin
        pal_idx = bsh;
        last_k  = 1'b1;
      end
    endcase
    pal_idx_ok = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);
  end

  // Direct formats gather little-endian bytes until a pixel is complete.
  always_comb begin
    gather_new = (byte_phase != 2'd3) ?
                 (byte_gather | (24'(s1_byte) << {byte_phase, 3'b000})) : byte_gather;
    phase_new  = byte_phase + 2'd1;
    case (fmt_eff)
      bpu_pkg::FMT_16BPP: phase_need = 2'd2;
      bpu_pkg::FMT_24BPP: phase_need = 2'd3;
      default:            phase_need = 2'd0;
    endcase
    fire = (phase_new == phase_need);
    if (fmt_eff == bpu_pkg::FMT_16BPP) begin
      direct_color = {gather_new[14:10], 3'b000, gather_new[9:5], 3'b000,
                      gather_new[4:0], 3'b000};
    end else begin
      direct_color = gather_new;
    end
  end

  // Step control for the byte register.
  always_comb begin
    is_data   = s1_valid && (s1_op == bpu_pkg::OP_PIXEL);
    emit      = is_data && in_data && (is_pal_fmt ? col_ok : fire);
    run_last  = is_pal_fmt ? (last_k || row_last) : 1'b1;
    s2_free   = !s2_valid || pix_out.ready;
    step_ok   = s1_valid && (!emit || s2_free);
    byte_done = (s1_op == bpu_pkg::OP_PALETTE) || !is_pal_fmt || !emit || run_last;
    s1_done   = step_ok && byte_done;
    pwr_ok    = step_ok && (s1_op == bpu_pkg::OP_PALETTE);
  end

  assign pix_in.ready = !s1_valid || s1_done;
  assign in_take      = pix_in.valid && pix_in.ready;

  // Byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_k     <= 3'd0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
      s1_k     <= 3'd0;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (step_ok) begin
      s1_k <= s1_k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op     <= pix_in.operation;
      s1_byte   <= pix_in.data_byte;
      s1_pidx   <= pix_in.palette_index;
      s1_pcolor <= pix_in.palette_color;
    end
  end

  // Frame counters advance per pixel and per finished byte.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      byte_gather    <= '0;
      byte_phase     <= '0;
      row_byte_count <= '0;
      column_count   <= '0;
      row_count      <= '0;
    end else if (step_ok && is_data) begin
      if (emit) begin
        column_count <= column_count + CW'(1);
      end
      if (!is_pal_fmt && in_data) begin
        if (fire) begin
          byte_gather <= '0;
          byte_phase  <= '0;
        end else begin
          byte_gather <= gather_new;
          byte_phase  <= phase_new;
        end
      end
      if (byte_done) begin
        if (rbc_inc >= padded) begin
          row_byte_count <= '0;
          column_count   <= '0;
          byte_gather    <= '0;
          byte_phase     <= '0;
          if (({1'b0, row_count} + (HW+1)'(1)) >= {1'b0, eff_h}) begin
            row_count <= '0;
          end else begin
            row_count <= row_count + HW'(1);
          end
        end else begin
          row_byte_count <= rbc_inc;
        end
      end
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pwr_ok && ({1'b0, s1_pidx} < 9'(PALETTE_DEPTH))) begin
      palette_mem[s1_pidx[AW-1:0]] <= s1_pcolor;
    end
    if (step_ok && emit && is_pal_fmt && pal_idx_ok) begin
      s2_pal_rd <= palette_mem[pal_idx[AW-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (step_ok && emit) begin
      s2_valid <= 1'b1;
    end else if (pix_out.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_ok && emit) begin
      s2_use_pal    <= is_pal_fmt;
      s2_pal_ok     <= pal_idx_ok;
      s2_direct     <= direct_color;
      s2_column     <= bpu_pkg::COORD_W'(column_count);
      s2_row        <= bpu_pkg::COORD_W'(rowno);
      s2_row_last   <= row_last;
      s2_frame_last <= frame_last;
      s2_run_last   <= run_last;
    end
  end

  assign pix_out.valid       = s2_valid;
  assign pix_out.pixel_color = s2_use_pal ? (s2_pal_ok ? s2_pal_rd : '0) : s2_direct;
  assign pix_out.column      = s2_column;
  assign pix_out.row_number  = s2_row;
  assign pix_out.row_last    = s2_row_last;
  assign pix_out.frame_last  = s2_frame_last;
  assign pix_out.run_last    = s2_run_last;

  // Checks on counter ranges and output flags.
`include "bitmap_pixel_unpacker_assert.svh"

  `BPU_ASSERT_SAME(a_col_range, clk, rst, 1'b1, column_count <= eff_w, "column count beyond width")
  `BPU_ASSERT_SAME(a_row_range, clk, rst, 1'b1, row_count < eff_h, "row count beyond height")
  `BPU_ASSERT_SAME(a_subpix_idx, clk, rst, s1_valid && (fmt_eff > bpu_pkg::FMT_4BPP), s1_k == 3'd0, "sub-pixel index moved in a one-pixel format")
  `BPU_ASSERT_SAME(a_frame_row, clk, rst, pix_out.valid && pix_out.frame_last, pix_out.row_last, "frame end without row end")

endmodule

`default_nettype wire
